// ----- rtl/brff_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brff_pkg
// Shared types and codes for the rectangle first-fit placer: request
// opcodes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package brff_pkg;

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic accept;
      logic start_read;
      logic read_en;
      logic win_init;
      logic win_step;
      logic find_commit;
      logic start_mark;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic bad_req;
      logic row_out;
      logic acc_done;
      logic steps_done;
      logic found;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/brff_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brff_ctrl
// Sequencer for the placer: walks each request through row gathering,
// window search, marking and result hand-off, and owns the result valid.
// ----------------------------------------------------------------------------
module brff_ctrl
   import brff_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_READ,
      S_WIN,
      S_FIND,
      S_MARK,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_clear ? S_RESULT : S_ROW;
            end
         end
         S_ROW: begin
            if (sts.bad_req || sts.row_out) begin
               state_in = S_RESULT;
            end else begin
               cmd.start_read = 1'b1;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            if (sts.acc_done) begin
               cmd.win_init = 1'b1;
               state_in     = S_WIN;
            end
         end
         S_WIN: begin
            cmd.win_step = 1'b1;
            if (sts.steps_done) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.find_commit = 1'b1;
            if (sts.found) begin
               cmd.start_mark = 1'b1;
               state_in       = S_MARK;
            end else begin
               state_in = S_ROW;
            end
         end
         S_MARK: begin
            cmd.read_en = 1'b1;
            if (sts.acc_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while held");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result not presented after emit");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |=> !cmd.accept)
      else $error("request taken during marking");

endmodule
`default_nettype wire

// ----- rtl/brff_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brff_datapath
// Occupancy row memory with per-row valid bits, row OR gathering, the
// doubling window search, first-fit column pick, marking and result register.
// ----------------------------------------------------------------------------
module brff_datapath
   import brff_pkg::*;
#(
   parameter int GRID_MAX = 64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_wr_en,
   input  wire  [6:0] csr_wr_data,
   input  wire        req_opcode,
   input  wire  [6:0] req_rect_width,
   input  wire  [6:0] req_rect_height,
   output logic       rsp_placed,
   output logic [5:0] rsp_pos_x,
   output logic [5:0] rsp_pos_y,
   input  cmd_type    cmd,
   output sts_type    sts
);

   localparam int IDX_W = $clog2(GRID_MAX);
   localparam int CNT_W = $clog2(GRID_MAX + 1);
   localparam int SZ_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam int BIT_W = $clog2(CNT_W);

   typedef logic [GRID_MAX-1:0] row_type;

   row_type                rows_mem [GRID_MAX];
   row_type                valid_ff;
   row_type                rd_data_ff;
   logic                   rd_vld_ff;
   logic                   rd_pend_ff;
   logic [SZ_W-1:0]        rd_addr_ff;
   logic [SZ_W-1:0]        wr_addr_ff;
   logic [CNT_W-1:0]       rd_cnt_ff;
   logic [CNT_W-1:0]       acc_cnt_ff;
   logic                   mark_mode_ff;
   row_type                acc_ff;
   row_type                mask_ff;
   row_type                g_ff;
   row_type                r_ff;
   logic [CNT_W-1:0]       off_ff;
   logic [BIT_W-1:0]       bit_ff;
   logic [6:0]             grid_size_ff;
   logic [6:0]             w_ff;
   logic [6:0]             h_ff;
   logic [SZ_W-1:0]        y_ff;
   logic [IDX_W-1:0]       xstart_ff;
   logic [IDX_W-1:0]       hint_x_ff;
   logic [IDX_W-1:0]       hint_y_ff;
   logic [IDX_W-1:0]       pos_x_ff;
   logic                   placed_ff;
   logic                   rsp_placed_ff;
   logic [5:0]             rsp_pos_x_ff;
   logic [5:0]             rsp_pos_y_ff;

   logic [SZ_W-1:0]        n;
   logic [CNT_W-1:0]       w_c;
   logic [CNT_W-1:0]       step_amt;
   row_type                eff_data;
   row_type                cand;
   logic [IDX_W-1:0]       fidx;
   logic                   rd_issue;

   always_comb begin
      if (grid_size_ff == 7'd0) begin
         n = SZ_W'(1);
      end else if (SZ_W'(grid_size_ff) > SZ_W'(GRID_MAX)) begin
         n = SZ_W'(GRID_MAX);
      end else begin
         n = SZ_W'(grid_size_ff);
      end
   end

   assign w_c      = CNT_W'(w_ff);
   assign step_amt = CNT_W'(1) << bit_ff;
   assign eff_data = rd_vld_ff ? rd_data_ff : '0;
   assign cand     = r_ff & ({GRID_MAX{1'b1}} << xstart_ff);
   assign rd_issue = cmd.read_en && (rd_cnt_ff != '0);

   always_comb begin
      fidx = '0;
      for (int i = GRID_MAX - 1; i >= 0; i--) begin
         if (cand[i]) begin
            fidx = IDX_W'(i);
         end
      end
   end

   assign sts.req_clear  = (req_opcode == OP_CLEAR);
   assign sts.bad_req    = (w_ff == 7'd0) || (h_ff == 7'd0) ||
                           (SZ_W'(w_ff) > n) || (SZ_W'(h_ff) > n);
   assign sts.row_out    = ({1'b0, y_ff} + (SZ_W + 1)'(h_ff)) > {1'b0, n};
   assign sts.acc_done   = (acc_cnt_ff == '0);
   assign sts.steps_done = (bit_ff == BIT_W'(CNT_W - 1));
   assign sts.found      = |cand;

   // row memory
   always_ff @(posedge clock) begin
      rd_data_ff <= rows_mem[rd_addr_ff[IDX_W-1:0]];
      if (rd_pend_ff && mark_mode_ff) begin
         rows_mem[wr_addr_ff[IDX_W-1:0]] <= eff_data | mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rd_cnt_ff    <= '0;
         acc_cnt_ff   <= '0;
         grid_size_ff <= 7'd64;
         hint_x_ff    <= '0;
         hint_y_ff    <= '0;
      end else begin
         rd_pend_ff <= rd_issue;
         if (csr_wr_en) begin
            grid_size_ff <= csr_wr_data;
         end
         if (cmd.accept && (req_opcode == OP_CLEAR)) begin
            valid_ff  <= '0;
            hint_x_ff <= '0;
            hint_y_ff <= '0;
         end
         if (rd_pend_ff && mark_mode_ff) begin
            valid_ff[wr_addr_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.find_commit && sts.found) begin
            hint_x_ff <= fidx;
            hint_y_ff <= y_ff[IDX_W-1:0];
         end
         if (cmd.start_read || cmd.start_mark) begin
            rd_cnt_ff  <= CNT_W'(h_ff);
            acc_cnt_ff <= CNT_W'(h_ff);
         end else begin
            if (rd_issue) begin
               rd_cnt_ff <= rd_cnt_ff - CNT_W'(1);
            end
            if (rd_pend_ff) begin
               acc_cnt_ff <= acc_cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= valid_ff[rd_addr_ff[IDX_W-1:0]];
      if (cmd.accept) begin
         w_ff      <= req_rect_width;
         h_ff      <= req_rect_height;
         y_ff      <= SZ_W'(hint_y_ff);
         xstart_ff <= hint_x_ff;
         placed_ff <= 1'b0;
      end
      if (cmd.start_read || cmd.start_mark) begin
         rd_addr_ff   <= y_ff;
         wr_addr_ff   <= y_ff;
         acc_ff       <= '0;
         mark_mode_ff <= cmd.start_mark;
      end else begin
         if (rd_issue) begin
            rd_addr_ff <= rd_addr_ff + SZ_W'(1);
         end
         if (rd_pend_ff) begin
            wr_addr_ff <= wr_addr_ff + SZ_W'(1);
            acc_ff     <= acc_ff | eff_data;
         end
      end
      if (cmd.start_mark) begin
         mask_ff <= (~({GRID_MAX{1'b1}} << w_c)) << fidx;
      end
      if (cmd.win_init) begin
         g_ff   <= ~acc_ff & ~({GRID_MAX{1'b1}} << n);
         r_ff   <= '1;
         off_ff <= '0;
         bit_ff <= '0;
      end else if (cmd.win_step) begin
         if (w_c[bit_ff]) begin
            r_ff   <= r_ff & (g_ff >> off_ff);
            off_ff <= off_ff + step_amt;
         end
         g_ff   <= g_ff & (g_ff >> step_amt);
         bit_ff <= bit_ff + BIT_W'(1);
      end
      if (cmd.find_commit) begin
         if (sts.found) begin
            pos_x_ff  <= fidx;
            placed_ff <= 1'b1;
         end else begin
            y_ff      <= y_ff + SZ_W'(1);
            xstart_ff <= '0;
         end
      end
      if (cmd.emit) begin
         rsp_placed_ff <= placed_ff;
         rsp_pos_x_ff  <= placed_ff ? 6'(pos_x_ff) : 6'd0;
         rsp_pos_y_ff  <= placed_ff ? 6'(y_ff) : 6'd0;
      end
   end

   assign rsp_placed = rsp_placed_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;

   a_no_extra_row_data: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (acc_cnt_ff != '0))
      else $error("row data arrived with no row outstanding");

   a_mark_in_grid: assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && mark_mode_ff) |-> (wr_addr_ff < n))
      else $error("marking outside the active grid");

   a_fit_in_grid: assert property (@(posedge clock) disable iff (reset)
      (cmd.find_commit && sts.found) |->
         (({1'b0, SZ_W'(fidx)} + {1'b0, SZ_W'(w_ff)}) <= {1'b0, n}))
      else $error("chosen column leaves the grid");

endmodule
`default_nettype wire

// ----- rtl/bitmap_rectangle_first_fit_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_rectangle_first_fit_unit
// First-fit rectangle placer over a square occupancy bitmap.
//
// Requests arrive on req_ (valid/ready): opcode place takes a rectangle
// size in cells, opcode clear empties the map and returns the hint to the
// origin. One response per request leaves on rsp_ (valid/ready) with
// placed and the top-left position; a failed place or a clear returns zeros.
// csr_wr_en/csr_wr_data set the grid side; write only while idle.
// A place scans rows from the hint: for each row tried, h rows are read
// from the row memory and ORed together, then the window-doubling steps
// and the column pick run, and a hit then marks the rows.
// One request is in flight at a time; the next is taken once the current
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the response; a finished request then waits.
// Reset empties the map (per-row valid bits, no sweep), zeroes the hint and
// sets the grid side to 64.
// ----------------------------------------------------------------------------
module bitmap_rectangle_first_fit_unit
   import brff_pkg::*;
#(
   parameter int GRID_MAX = 64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_wr_en,
   input  wire  [6:0] csr_wr_data,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_opcode,
   input  wire  [6:0] req_rect_width,
   input  wire  [6:0] req_rect_height,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic       rsp_placed,
   output logic [5:0] rsp_pos_x,
   output logic [5:0] rsp_pos_y
);

   cmd_type cmd;
   sts_type sts;

   brff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brff_datapath #(
      .GRID_MAX (GRID_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_opcode      (req_opcode),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_placed      (rsp_placed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle first-fit placer. A behavioural
// copy of the occupancy map and search hint predicts every response; a
// monitor compares each response with the oldest prediction. Directed cases
// cover fields at their limits and grid side changes, then randomised
// place/clear mixes run over several grid sides under varied flow control,
// with one long response stall that backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb
   import brff_pkg::*;
();

   typedef struct packed {
      logic       placed;
      logic [5:0] pos_x;
      logic [5:0] pos_y;
   } placement_type;

   localparam int GRID_SIDE_MAX = 64;
   localparam int STALL_LIMIT   = 50000;

   logic       clock;
   logic       reset           = 1'b1;
   logic       csr_wr_en       = 1'b0;
   logic [6:0] csr_wr_data     = 7'd0;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic       req_opcode      = OP_PLACE;
   logic [6:0] req_rect_width  = 7'd0;
   logic [6:0] req_rect_height = 7'd0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic       rsp_placed;
   logic [5:0] rsp_pos_x;
   logic [5:0] rsp_pos_y;

   bitmap_rectangle_first_fit_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_placed      (rsp_placed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

   bit [63:0]  occupancy [GRID_SIDE_MAX];
   int         hint_x;
   int         hint_y;
   logic [6:0] grid_setting = 7'd64;

   placement_type placement_log [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_len;
   int hold_off_left;
   int failure_count;
   int responses_checked;
   int place_count;
   int fit_count;
   int clear_count;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int active_side();
      if (grid_setting == 7'd0)
         return 1;
      if (grid_setting > GRID_SIDE_MAX)
         return GRID_SIDE_MAX;
      return int'(grid_setting);
   endfunction

   function automatic bit region_free(int x, int y, int w, int h, int n);
      bit [63:0] mask;
      if (x + w > n || y + h > n)
         return 1'b0;
      mask = ({64{1'b1}} >> (64 - w)) << x;
      for (int r = y; r < y + h; r++)
         if ((occupancy[r] & mask) != 64'd0)
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic placement_type predict_placement(logic op, logic [6:0] w,
                                                       logic [6:0] h);
      placement_type res;
      bit [63:0]     mask;
      int            n;
      int            x;
      int            y;
      res = '0;
      n = active_side();
      if (op == OP_CLEAR) begin
         foreach (occupancy[r])
            occupancy[r] = 64'd0;
         hint_x = 0;
         hint_y = 0;
         return res;
      end
      if (w == 7'd0 || h == 7'd0 || w > n || h > n)
         return res;
      x = hint_x;
      y = hint_y;
      while (y < n) begin
         if (x >= n) begin
            x = 0;
            y++;
         end else if (!occupancy[y][x] && region_free(x, y, w, h, n)) begin
            mask = ({64{1'b1}} >> (64 - w)) << x;
            for (int r = y; r < y + h; r++)
               occupancy[r] |= mask;
            hint_x = x;
            hint_y = y;
            res.placed = 1'b1;
            res.pos_x  = x[5:0];
            res.pos_y  = y[5:0];
            return res;
         end else begin
            x++;
         end
      end
      return res;
   endfunction

   task automatic send_request(input logic op, input logic [6:0] w, input logic [6:0] h);
      placement_type predicted;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_rect_width  <= w;
      req_rect_height <= h;
      do @(posedge clock); while (!req_ready);
      predicted = predict_placement(op, w, h);
      placement_log = {placement_log, predicted};
      if (op == OP_CLEAR) begin
         clear_count++;
      end else begin
         place_count++;
         if (predicted.placed)
            fit_count++;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (placement_log.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_grid_size(input logic [6:0] value);
      drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      grid_setting  = value;
   endtask

   task automatic test_directed_cases();
      send_request(OP_PLACE, 7'd64, 7'd64);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_CLEAR, 7'd127, 7'd0);
      send_request(OP_PLACE, 7'd0, 7'd3);
      send_request(OP_PLACE, 7'd3, 7'd0);
      send_request(OP_PLACE, 7'd65, 7'd1);
      send_request(OP_PLACE, 7'd1, 7'd127);
      send_request(OP_PLACE, 7'd63, 7'd1);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_PLACE, 7'd1, 7'd63);
      send_request(OP_PLACE, 7'd64, 7'd1);
      send_request(OP_CLEAR, 7'd0, 7'd127);
      send_request(OP_PLACE, 7'd2, 7'd2);
      send_request(OP_PLACE, 7'd2, 7'd2);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_CLEAR, 7'd0, 7'd0);
      send_request(OP_PLACE, 7'd64, 7'd40);
      send_request(OP_PLACE, 7'd1, 7'd1);
      write_grid_size(7'd8);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_CLEAR, 7'd0, 7'd0);
      send_request(OP_PLACE, 7'd8, 7'd8);
      write_grid_size(7'd0);
      send_request(OP_CLEAR, 7'd0, 7'd0);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_PLACE, 7'd1, 7'd1);
      send_request(OP_PLACE, 7'd2, 7'd1);
      write_grid_size(7'd127);
      send_request(OP_CLEAR, 7'd0, 7'd0);
      send_request(OP_PLACE, 7'd64, 7'd64);
   endtask

   task automatic test_random_placements(input int n_items, input logic [6:0] grid);
      int         side;
      int         pick;
      int         limit;
      logic [6:0] w;
      logic [6:0] h;
      write_grid_size(grid);
      side  = active_side();
      limit = (side > 3) ? side / 4 : 1;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_request(OP_CLEAR, 7'($urandom_range(127)), 7'($urandom_range(127)));
         end else begin
            if (pick < 10) begin
               w = 7'($urandom_range(127));
               h = 7'($urandom_range(127));
            end else if (pick < 15) begin
               w = 7'($urandom_range(1, side));
               h = 7'($urandom_range(1, side));
            end else begin
               w = 7'($urandom_range(1, limit));
               h = 7'($urandom_range(1, limit));
            end
            send_request(OP_PLACE, w, h);
         end
      end
   endtask

   task automatic test_receiver_hold_off();
      write_grid_size(7'd16);
      send_request(OP_CLEAR, 7'd0, 7'd0);
      drain();
      hold_off_len = 400;
      for (int i = 0; i < 24; i++)
         send_request(OP_PLACE, 7'($urandom_range(1, 3)), 7'($urandom_range(1, 3)));
   endtask

   // hold responses for a requested stretch, otherwise stall at random
   always @(posedge clock) begin
      if (hold_off_len != 0) begin
         hold_off_left = hold_off_len;
         hold_off_len  = 0;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      placement_type predicted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (placement_log.size() == 0) begin
            failure_count++;
            if (failure_count <= 10)
               $display("unexpected response: placed=%0b x=%0d y=%0d",
                        rsp_placed, rsp_pos_x, rsp_pos_y);
         end else begin
            predicted = placement_log.pop_front();
            responses_checked++;
            if (rsp_placed !== predicted.placed || rsp_pos_x !== predicted.pos_x ||
                rsp_pos_y !== predicted.pos_y) begin
               failure_count++;
               if (failure_count <= 10)
                  $display({"mismatch on response %0d: expected placed=%0b x=%0d y=%0d,",
                            " got placed=%0b x=%0d y=%0d"},
                           responses_checked, predicted.placed, predicted.pos_x,
                           predicted.pos_y, rsp_placed, rsp_pos_x, rsp_pos_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      foreach (occupancy[r])
         occupancy[r] = 64'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 8;
      recv_idle_pct = 48;
      test_directed_cases();
      test_random_placements(210, 7'd64);
      test_random_placements(210, 7'd16);
      test_random_placements(210, 7'd1);

      send_idle_pct = 48;
      recv_idle_pct = 8;
      test_random_placements(210, 7'd8);
      test_random_placements(210, 7'd33);
      test_random_placements(210, 7'd5);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_placements(210, 7'd0);
      test_random_placements(210, 7'd127);
      test_random_placements(210, 7'd24);
      test_receiver_hold_off();

      drain();
      repeat (100) @(posedge clock);
      $display("%0d responses checked: %0d place requests (%0d fitted), %0d clears,",
               responses_checked, place_count, fit_count, clear_count);
      $display("grid sides 0 to 127 written, flow control varied, one long response stall");
      if (failure_count == 0 && placement_log.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/brff_pkg.sv
rtl/brff_ctrl.sv
rtl/brff_datapath.sv
rtl/bitmap_rectangle_first_fit_unit.sv
test/tb.sv
